// ===== hdl/uhks_pkg.sv =====
package uhks_pkg;

    localparam int MAX_SLOTS   = 6;
    localparam int KEY_SLOTS_D = 6;
    localparam int QDEPTH      = 2;

    localparam logic [31:0] CP_MAX  = 32'h0010_FFFF;
    localparam logic [31:0] SURR_LO = 32'h0000_D800;
    localparam logic [31:0] SURR_HI = 32'h0000_DFFF;

    localparam logic [7:0] SHIFT_MASK     = 8'h22;
    localparam logic [7:0] MOD_CTRL_SHIFT = 8'h03;
    localparam logic [7:0] USAGE_A        = 8'h04;
    localparam logic [7:0] USAGE_U        = 8'h18;
    localparam logic [7:0] USAGE_1        = 8'h1E;
    localparam logic [7:0] USAGE_0        = 8'h27;
    localparam logic [7:0] USAGE_SPACE    = 8'h2C;
    localparam logic [7:0] USAGE_CAPS     = 8'h39;

    localparam logic [2:0] DIG_TOP = 3'd5;
    localparam logic [2:0] DIG_MID = 3'd4;
    localparam logic [2:0] DIG_LOW = 3'd3;

    typedef logic [MAX_SLOTS-1:0][7:0] t_slots;

    typedef struct packed {
        logic [7:0]  mods;
        t_slots      slots;
        logic        caps;
        logic [23:0] cp;
        logic [2:0]  start;
    } t_job;

    function automatic logic [7:0] f_digit_key(logic [3:0] d);
        logic [7:0] k;
        if (d == 4'd0) begin
            k = USAGE_0;
        end else if (d < 4'd10) begin
            k = USAGE_1 + {4'd0, d} - 8'd1;
        end else begin
            k = USAGE_A + {4'd0, d} - 8'd10;
        end
        return k;
    endfunction

    function automatic t_slots f_insert(t_slots s, logic [7:0] key, logic [2:0] n);
        t_slots r;
        logic   present;
        logic   done;
        r       = s;
        present = 1'b0;
        done    = 1'b0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (i < int'(n) && s[i] == key) begin
                present = 1'b1;
            end
        end
        if (key != 8'd0 && !present) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                if (!done && i < int'(n) && s[i] == 8'd0) begin
                    r[i] = key;
                    done = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/uhks_front.sv =====
module uhks_front #(
    parameter int KEY_SLOTS = uhks_pkg::KEY_SLOTS_D
) (
    input  logic [31:0]          i_plain,
    input  logic [31:0]          i_alt,
    input  logic [7:0]           i_mods,
    input  uhks_pkg::t_slots     i_slots,
    input  logic                 i_caps,
    output logic                 o_keep,
    output uhks_pkg::t_job       o_job
);

    logic [31:0]      cp;
    logic             shifted;
    logic             has_room;
    logic             cp_ok;
    uhks_pkg::t_slots masked;

    always_comb begin
        masked   = '0;
        has_room = 1'b0;
        for (int i = 0; i < uhks_pkg::MAX_SLOTS; i++) begin
            if (i < KEY_SLOTS) begin
                masked[i] = i_slots[i];
                if (i_slots[i] == 8'd0) begin
                    has_room = 1'b1;
                end
            end
        end
    end

    assign shifted = (i_mods & uhks_pkg::SHIFT_MASK) != 8'd0;
    assign cp      = (shifted != i_caps) ? i_alt : i_plain;
    assign cp_ok   = (cp <= uhks_pkg::CP_MAX) &&
                     !(cp inside {[uhks_pkg::SURR_LO:uhks_pkg::SURR_HI]});
    assign o_keep  = cp_ok && has_room;

    always_comb begin
        o_job.mods  = i_mods;
        o_job.slots = masked;
        o_job.caps  = i_caps;
        o_job.cp    = cp[23:0];
        if (cp[23:20] != 4'd0) begin
            o_job.start = uhks_pkg::DIG_TOP;
        end else if (cp[19:16] != 4'd0) begin
            o_job.start = uhks_pkg::DIG_MID;
        end else begin
            o_job.start = uhks_pkg::DIG_LOW;
        end
    end

endmodule

// ===== hdl/uhks_queue.sv =====
module uhks_queue #(
    parameter int DEPTH = uhks_pkg::QDEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  uhks_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output uhks_pkg::t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    uhks_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

// ===== hdl/uhks_back.sv =====
module uhks_back #(
    parameter int KEY_SLOTS = uhks_pkg::KEY_SLOTS_D
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  uhks_pkg::t_job   i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_mods,
    output uhks_pkg::t_slots o_slots,
    output logic             o_last
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_CAPS_A,
        ST_CSU,
        ST_DIGIT,
        ST_SPACE,
        ST_CAPS_B,
        ST_RESTORE
    } t_state;

    t_state           r_state;
    logic             r_rel;
    logic [2:0]       r_dig;
    logic             r_valid;
    logic [7:0]       r_mods;
    uhks_pkg::t_slots r_slots;
    logic             r_last;

    logic             emit;
    logic [3:0]       nib;
    logic [7:0]       key;
    logic [7:0]       tap_mods;
    logic [7:0]       n_mods;
    uhks_pkg::t_slots n_slots;

    assign emit = i_job_valid && (!r_valid || i_ready);
    assign nib  = 4'(i_job.cp >> {r_dig, 2'b00});
    assign o_pop = emit && (r_state == ST_RESTORE);

    always_comb begin
        tap_mods = 8'd0;
        case (r_state)
            ST_CAPS_A, ST_CAPS_B: key = uhks_pkg::USAGE_CAPS;
            ST_CSU: begin
                key      = uhks_pkg::USAGE_U;
                tap_mods = uhks_pkg::MOD_CTRL_SHIFT;
            end
            ST_DIGIT: key = uhks_pkg::f_digit_key(nib);
            ST_SPACE: key = uhks_pkg::USAGE_SPACE;
            default:  key = 8'd0;
        endcase
    end

    always_comb begin
        n_mods  = 8'd0;
        n_slots = i_job.slots;
        if (r_state == ST_RESTORE) begin
            n_mods = i_job.mods;
        end else if (r_state != ST_CLEAR && !r_rel) begin
            n_mods  = tap_mods;
            n_slots = uhks_pkg::f_insert(i_job.slots, key, 3'(KEY_SLOTS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_rel   <= 1'b0;
            r_dig   <= '0;
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
            r_mods  <= n_mods;
            r_slots <= n_slots;
            r_last  <= r_state == ST_RESTORE;
            case (r_state)
                ST_CLEAR: r_state <= i_job.caps ? ST_CAPS_A : ST_CSU;
                ST_RESTORE: r_state <= ST_CLEAR;
                default: begin
                    r_rel <= !r_rel;
                    if (r_rel) begin
                        case (r_state)
                            ST_CAPS_A: r_state <= ST_CSU;
                            ST_CSU: begin
                                r_state <= ST_DIGIT;
                                r_dig   <= i_job.start;
                            end
                            ST_DIGIT: begin
                                if (r_dig == 3'd0) begin
                                    r_state <= ST_SPACE;
                                end else begin
                                    r_dig <= r_dig - 3'd1;
                                end
                            end
                            ST_SPACE: r_state <= i_job.caps ? ST_CAPS_B : ST_RESTORE;
                            default:  r_state <= ST_RESTORE;
                        endcase
                    end
                end
            endcase
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_mods  = r_mods;
    assign o_slots = r_slots;
    assign o_last  = r_last;

    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |-> i_job_valid)
        else $error("job left queue mid run");
    a_dig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIGIT) |-> (r_dig <= uhks_pkg::DIG_TOP))
        else $error("digit index out of range");
    a_rel_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR || r_state == ST_RESTORE) |-> !r_rel)
        else $error("release phase outside a tap");
    a_last_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_last && r_state == ST_CLEAR))
        else $error("run end without last beat");

endmodule

// ===== hdl/unicode_hex_keystroke_sequencer.sv =====
// Unicode hex entry sequencer, 6KRO keyboard reports.
// s_axis: one beat per key press. tdata holds both code points, the held
//   modifier byte and the held key slots; tuser holds the caps lock state.
// m_axis: one beat per emitted report; tlast marks the restoring report.
// A press becomes a run of 14 to 22 report beats: clear, optional caps tap,
//   Ctrl+Shift+U tap, 4 to 6 hex digit taps, space tap, optional caps tap,
//   restore. Invalid code points or a full report give no beats.
// The back-end sequencer emits one report per cycle unless m_axis_tready stalls
//   it; a press passes through the job queue and then the output register.
// A 2-entry job queue sits between classification and the sequencer, so the
//   input keeps taking presses while a run is in progress.
// Output is registered; a stall on m_axis_tready holds the current beat and
//   pauses the sequencer, and the input stalls once the queue fills.
// Reset empties the queue and output register; no beat is pending after it.
module unicode_hex_keystroke_sequencer #(
    parameter int KEY_SLOTS = uhks_pkg::KEY_SLOTS_D
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // plain_codepoint, alternate_codepoint, held_modifiers, held_slot_0..5
    input  logic [119:0] s_axis_tdata,
    // caps_lock_on
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_modifiers, out_slot_0..5
    output logic [55:0]  m_axis_tdata,
    output logic         m_axis_tlast
);

    logic             keep;
    logic             full;
    logic             push;
    logic             pop;
    logic             job_valid;
    uhks_pkg::t_job   in_job;
    uhks_pkg::t_job   head_job;
    logic [7:0]       out_mods;
    uhks_pkg::t_slots out_slots;

    assign s_axis_tready = !full;
    assign push          = s_axis_tvalid && !full && keep;

    uhks_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
        .i_plain (s_axis_tdata[31:0]),
        .i_alt   (s_axis_tdata[63:32]),
        .i_mods  (s_axis_tdata[71:64]),
        .i_slots (s_axis_tdata[119:72]),
        .i_caps  (s_axis_tuser),
        .o_keep  (keep),
        .o_job   (in_job)
    );

    uhks_queue #(.DEPTH(uhks_pkg::QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (in_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (head_job)
    );

    uhks_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_mods      (out_mods),
        .o_slots     (out_slots),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {out_slots, out_mods};

endmodule
